>>> rtl/afgc_pkg.sv
// Package for the audio filter and gain chain: shared types, register
// indexes, limits and the truncate-and-saturate helpers.
// No dependencies.
`default_nettype none

package afgc_pkg;

   // Filter modes as seen after decoding (unused codes decode to none)
   typedef enum logic [2:0] {
      MODE_NONE     = 3'd0,
      MODE_LOWPASS  = 3'd1,
      MODE_HIGHPASS = 3'd2,
      MODE_BANDPASS = 3'd3,
      MODE_GATE     = 3'd4
   } mode_type;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_MODE   = 2'd0,
      CSR_ALPHA  = 2'd1,
      CSR_THRESH = 2'd2,
      CSR_GAIN   = 2'd3
   } csr_index_type;

   localparam int CSR_DATA_W = 16;

   // Register limits and reset values
   localparam logic [16:0] ALPHA_ONE    = 17'd32768;
   localparam logic [13:0] THRESH_MAX   = 14'd10000;
   localparam logic [15:0] GAIN_MAX     = 16'd40960;
   localparam logic [15:0] ALPHA_RESET  = 16'd6554;
   localparam logic [13:0] THRESH_RESET = 14'd500;
   localparam logic [15:0] GAIN_RESET   = 16'd4096;

   // Fixed-point shifts
   localparam int ALPHA_SHIFT = 15;
   localparam int GAIN_SHIFT  = 12;

   // Divide-by-three as multiply by ceil(2^18 / 3), exact below 2^17
   localparam int RECIP3_SHIFT = 18;

   typedef logic signed [15:0] sample_type;
   typedef logic signed [17:0] mul_op_type;
   typedef logic signed [35:0] mul_prod_type;
   typedef logic signed [36:0] acc_type;

   localparam mul_op_type RECIP3 = 18'sd87382;

   // Effective configuration seen by the datapath
   typedef struct packed {
      mode_type    mode;
      logic [16:0] alpha;
      logic [13:0] threshold;
      logic [15:0] gain;
      logic        mode_wr;
   } cfg_type;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_HP_MUL,
      ST_HP_DONE,
      ST_LP_MUL,
      ST_LP_DONE,
      ST_WIN,
      ST_AVG_MUL,
      ST_AVG_DONE,
      ST_GAIN_MUL,
      ST_OUT
   } seq_state_type;

   // Clamp to int16
   function automatic sample_type sat16(input acc_type v);
      sample_type r;
      if (v > 37'sd32767) begin
         r = 16'sh7FFF;
      end else if (v < -37'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   // Divide by 2^sh truncating toward zero, then clamp to int16
   function automatic sample_type div_sat(input acc_type v, input int sh);
      acc_type bias;
      acc_type q;
      bias = (v < 0) ? ((acc_type'(1) <<< sh) - acc_type'(1)) : '0;
      q    = (v + bias) >>> sh;
      return sat16(q);
   endfunction

endpackage

`default_nettype wire

>>> rtl/afgc_mul.sv
// Shared signed 18x18 multiplier with a registered product.
// Depends on afgc_pkg for operand and product types.
`default_nettype none

module afgc_mul (
   input  wire                    clock,
   input  wire                    mul_start,
   input  afgc_pkg::mul_op_type   mul_a,
   input  afgc_pkg::mul_op_type   mul_b,
   output afgc_pkg::mul_prod_type mul_prod
);
   import afgc_pkg::*;

   mul_prod_type prod_ff;

   // Product holds until the next start
   always_ff @(posedge clock) begin
      if (mul_start) begin
         prod_ff <= mul_a * mul_b;
      end
   end

   assign mul_prod = prod_ff;

endmodule

`default_nettype wire

>>> rtl/afgc_csr.sv
// Configuration registers of the filter chain, with clamping of
// out-of-range values and mode decoding. Depends on afgc_pkg.
`default_nettype none

module afgc_csr (
   input  wire                clock,
   input  wire                reset,
   input  wire                csr_wr_en,
   input  wire  [1:0]         csr_index,
   input  wire  [15:0]        csr_wdata,
   output afgc_pkg::cfg_type  cfg
);
   import afgc_pkg::*;

   logic [2:0]  mode_ff;
   logic [15:0] alpha_ff;
   logic [13:0] thresh_ff;
   logic [15:0] gain_ff;
   mode_type    mode_dec;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= 3'd0;
         alpha_ff  <= ALPHA_RESET;
         thresh_ff <= THRESH_RESET;
         gain_ff   <= GAIN_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_MODE:   mode_ff   <= csr_wdata[2:0];
            CSR_ALPHA:  alpha_ff  <= csr_wdata;
            CSR_THRESH: thresh_ff <= csr_wdata[13:0];
            CSR_GAIN:   gain_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Unused mode codes run as no filter
   always_comb begin
      case (mode_ff)
         MODE_LOWPASS:  mode_dec = MODE_LOWPASS;
         MODE_HIGHPASS: mode_dec = MODE_HIGHPASS;
         MODE_BANDPASS: mode_dec = MODE_BANDPASS;
         MODE_GATE:     mode_dec = MODE_GATE;
         default:       mode_dec = MODE_NONE;
      endcase
   end

   // Clamped values
   always_comb begin
      cfg.mode      = mode_dec;
      cfg.alpha     = ({1'b0, alpha_ff} > ALPHA_ONE) ? ALPHA_ONE : {1'b0, alpha_ff};
      cfg.threshold = (thresh_ff > THRESH_MAX) ? THRESH_MAX : thresh_ff;
      cfg.gain      = (gain_ff > GAIN_MAX) ? GAIN_MAX : gain_ff;
      cfg.mode_wr   = csr_wr_en && (csr_index == CSR_MODE);
   end

endmodule

`default_nettype wire

>>> rtl/audio_filter_gain_chain_top.sv
// Top level of the audio filter and gain chain: sequencer, filter and
// window state, output register. Depends on afgc_pkg, afgc_csr, afgc_mul.
`default_nettype none

// Filters signed 16-bit samples (none, one-pole lowpass, one-pole highpass,
// bandpass as highpass then lowpass, or noise gate), replaces interior
// samples of each frame by the centered 3-tap average truncated toward
// zero, and applies a Q4.12 gain with int16 saturation. Results lag input
// by one sample inside a frame; a sample with frame_end gives up to two
// results, rsp_run_last marking the last one of each transaction. All
// products run through one 18x18 multiplier under a small sequencer, so
// one transaction steps through accept, a multiply and a load per filter
// stage in use, a window step, a multiply and a load for the average when
// one is formed, and per result a multiply and then the load of the output
// register, which waits for that register to free up. The multiplier is
// the limit. The next transaction is accepted while the last result still
// waits in the output register.
module audio_filter_gain_chain_top (
   input  wire         clock,
   input  wire         reset,
   // input samples
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [15:0] req_sample_in,
   input  wire         req_frame_end_in,
   // results
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [15:0] rsp_sample_out,
   output logic        rsp_frame_end_out,
   output logic        rsp_run_last,
   // configuration
   input  wire         csr_wr_en,
   input  wire  [1:0]  csr_index,
   input  wire  [15:0] csr_wdata
);
   import afgc_pkg::*;

   cfg_type       cfg;
   seq_state_type state_ff, state_in;

   sample_type    x_ff, x_in;
   logic          end_ff, end_in;
   sample_type    f_ff, f_in;
   sample_type    s_ff, s_in;
   sample_type    hp_in_ff, hp_in_in;
   sample_type    hp_out_ff, hp_out_in;
   sample_type    lp_ff, lp_in;
   sample_type    older_ff, older_in;
   sample_type    newer_ff, newer_in;
   logic [1:0]    pos_ff, pos_in;
   logic          fe_ff, fe_in;
   logic          pend_ff, pend_in;
   logic          out_valid_ff, out_valid_in;
   sample_type    out_sample_ff, out_sample_in;
   logic          out_fe_ff, out_fe_in;
   logic          out_last_ff, out_last_in;

   logic          mul_start;
   mul_op_type    mul_a, mul_b;
   mul_prod_type  mul_prod;

   logic          out_free;
   logic signed [16:0] x_ext;
   logic [16:0]        x_mag;
   sample_type         gated;
   logic signed [17:0] avg_sum;
   logic [16:0]        avg_mag;
   logic signed [17:0] avg_q;

   afgc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   afgc_mul u_mul (
      .clock     (clock),
      .mul_start (mul_start),
      .mul_a     (mul_a),
      .mul_b     (mul_b),
      .mul_prod  (mul_prod)
   );

   assign out_free  = !out_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   // Noise gate on the incoming sample (magnitude of -32768 is 32768)
   assign x_ext = 17'(signed'(req_sample_in));
   assign x_mag = req_sample_in[15] ? 17'(-x_ext) : 17'(x_ext);
   assign gated = (x_mag < {3'b000, cfg.threshold}) ? 16'sd0 : signed'(req_sample_in);

   // Three-tap sum and its magnitude for the divide by three
   assign avg_sum = 18'(older_ff) + 18'(newer_ff) + 18'(f_ff);
   assign avg_mag = avg_sum[17] ? 17'(-avg_sum) : 17'(avg_sum);
   assign avg_q   = avg_sum[17] ? -signed'({1'b0, mul_prod[34:18]})
                                :  signed'({1'b0, mul_prod[34:18]});

   // Multiplier operand selection
   assign mul_start = state_ff inside {ST_HP_MUL, ST_LP_MUL, ST_AVG_MUL, ST_GAIN_MUL};

   always_comb begin
      case (state_ff)
         ST_HP_MUL: begin
            mul_a = signed'({1'b0, cfg.alpha});
            mul_b = 18'(hp_out_ff) + 18'(x_ff) - 18'(hp_in_ff);
         end
         ST_LP_MUL: begin
            mul_a = signed'({1'b0, cfg.alpha});
            mul_b = 18'(f_ff) - 18'(lp_ff);
         end
         ST_AVG_MUL: begin
            mul_a = signed'({1'b0, avg_mag});
            mul_b = RECIP3;
         end
         ST_GAIN_MUL: begin
            mul_a = 18'(s_ff);
            mul_b = signed'({2'b00, cfg.gain});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (cfg.mode)
                  MODE_HIGHPASS, MODE_BANDPASS: state_in = ST_HP_MUL;
                  MODE_LOWPASS:                 state_in = ST_LP_MUL;
                  default:                      state_in = ST_WIN;
               endcase
            end
         end
         ST_HP_MUL:  state_in = ST_HP_DONE;
         ST_HP_DONE: state_in = (cfg.mode == MODE_BANDPASS) ? ST_LP_MUL : ST_WIN;
         ST_LP_MUL:  state_in = ST_LP_DONE;
         ST_LP_DONE: state_in = ST_WIN;
         ST_WIN: begin
            if (pos_ff == 2'd0) begin
               state_in = end_ff ? ST_GAIN_MUL : ST_IDLE;
            end else if (pos_ff == 2'd1) begin
               state_in = ST_GAIN_MUL;
            end else begin
               state_in = ST_AVG_MUL;
            end
         end
         ST_AVG_MUL:  state_in = ST_AVG_DONE;
         ST_AVG_DONE: state_in = ST_GAIN_MUL;
         ST_GAIN_MUL: state_in = ST_OUT;
         ST_OUT: begin
            if (out_free) begin
               state_in = pend_ff ? ST_GAIN_MUL : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and output register updates
   always_comb begin
      x_in          = x_ff;
      end_in        = end_ff;
      f_in          = f_ff;
      s_in          = s_ff;
      hp_in_in      = hp_in_ff;
      hp_out_in     = hp_out_ff;
      lp_in         = lp_ff;
      older_in      = older_ff;
      newer_in      = newer_ff;
      pos_in        = pos_ff;
      fe_in         = fe_ff;
      pend_in       = pend_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_sample_in = out_sample_ff;
      out_fe_in     = out_fe_ff;
      out_last_in   = out_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               x_in   = signed'(req_sample_in);
               end_in = req_frame_end_in;
               f_in   = (cfg.mode == MODE_GATE) ? gated : signed'(req_sample_in);
            end
         end
         ST_HP_DONE: begin
            f_in      = div_sat(acc_type'(mul_prod), ALPHA_SHIFT);
            hp_in_in  = x_ff;
            hp_out_in = div_sat(acc_type'(mul_prod), ALPHA_SHIFT);
         end
         ST_LP_DONE: begin
            f_in  = div_sat(acc_type'(mul_prod) + (acc_type'(lp_ff) <<< ALPHA_SHIFT),
                            ALPHA_SHIFT);
            lp_in = div_sat(acc_type'(mul_prod) + (acc_type'(lp_ff) <<< ALPHA_SHIFT),
                            ALPHA_SHIFT);
         end
         ST_WIN: begin
            if (pos_ff == 2'd0) begin
               // frame start: hold the sample, or pass a one-sample frame
               if (end_ff) begin
                  s_in    = f_ff;
                  fe_in   = 1'b1;
                  pend_in = 1'b0;
               end else begin
                  newer_in = f_ff;
                  pos_in   = 2'd1;
               end
            end else begin
               s_in    = newer_ff;
               fe_in   = 1'b0;
               pend_in = end_ff;
            end
         end
         ST_AVG_DONE: begin
            s_in = avg_q[15:0];
         end
         ST_OUT: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_sample_in = div_sat(acc_type'(mul_prod), GAIN_SHIFT);
               out_fe_in     = fe_ff;
               out_last_in   = !pend_ff;
               if (pend_ff) begin
                  // frame end follows: the current sample goes out unaveraged
                  s_in    = f_ff;
                  fe_in   = 1'b1;
                  pend_in = 1'b0;
               end else if (end_ff) begin
                  pos_in = 2'd0;
               end else begin
                  older_in = newer_ff;
                  newer_in = f_ff;
                  pos_in   = 2'd2;
               end
            end
         end
         default: ;
      endcase

      // Mode write clears the filter outputs
      if (cfg.mode_wr) begin
         hp_out_in = '0;
         lp_in     = '0;
      end
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         hp_in_ff     <= '0;
         hp_out_ff    <= '0;
         lp_ff        <= '0;
         older_ff     <= '0;
         newer_ff     <= '0;
         pos_ff       <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hp_in_ff     <= hp_in_in;
         hp_out_ff    <= hp_out_in;
         lp_ff        <= lp_in;
         older_ff     <= older_in;
         newer_ff     <= newer_in;
         pos_ff       <= pos_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff          <= x_in;
      end_ff        <= end_in;
      f_ff          <= f_in;
      s_ff          <= s_in;
      fe_ff         <= fe_in;
      pend_ff       <= pend_in;
      out_sample_ff <= out_sample_in;
      out_fe_ff     <= out_fe_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_sample_out    = out_sample_ff;
   assign rsp_frame_end_out = out_fe_ff;
   assign rsp_run_last      = out_last_ff;

endmodule

`default_nettype wire

>>> tb/tb_audio_filter_gain_chain_top.sv
// Self-checking testbench for audio_filter_gain_chain_top: valid/ready driver,
// result monitor and a cycle-free predictor of the filter, average and gain.
// Depends on afgc_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb_audio_filter_gain_chain_top;
   import afgc_pkg::*;

   localparam int PHASES        = 12;
   localparam int PHASE_ITEMS   = 144;
   localparam int SETTLE_CYCLES = 32;
   localparam int HOLD_CYCLES   = 400;
   localparam int PRESSURE_PHASE = 4;

   typedef struct {
      logic [15:0] sample;
      logic        frame_end;
   } sample_item_type;

   typedef struct {
      logic [15:0] sample;
      logic        frame_end;
      logic        run_last;
   } chain_result_type;

   typedef enum int {
      FLAV_FULL,
      FLAV_EXTREME,
      FLAV_NEAR_GATE,
      FLAV_QUIET
   } sample_flavor_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [15:0] req_sample_in = '0;
   logic        req_frame_end_in = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_sample_out;
   logic        rsp_frame_end_out;
   logic        rsp_run_last;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   // Stimulus and expectation stores
   sample_item_type  samples_to_send[$];
   chain_result_type results_due[$];
   sample_item_type  next_item;
   int               mismatches = 0;
   int               gap_pct = 0;
   int               stall_pct = 0;
   logic             hold_arm = 1'b0;
   int               hold_left = 0;

   // Predictor copy of the registers and the filter/window state
   logic [2:0]         cfg_mode;
   logic [15:0]        cfg_alpha;
   logic [13:0]        cfg_thresh;
   logic [15:0]        cfg_gain;
   logic signed [15:0] hpf_x_prev, hpf_y_prev, lpf_y_prev;
   logic signed [15:0] tap_old, tap_new;
   int                 frame_fill;

   audio_filter_gain_chain_top u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_sample_in     (req_sample_in),
      .req_frame_end_in  (req_frame_end_in),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_sample_out    (rsp_sample_out),
      .rsp_frame_end_out (rsp_frame_end_out),
      .rsp_run_last      (rsp_run_last),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // 100 MHz clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Clamp to int16
   function automatic logic signed [15:0] clamp16(input longint v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return 16'(v);
   endfunction

   function automatic longint eff_alpha();
      return (cfg_alpha > 16'(ALPHA_ONE)) ? longint'(ALPHA_ONE) : longint'(cfg_alpha);
   endfunction

   // One-pole highpass, updates its own memory
   function automatic logic signed [15:0] hp_stage(input logic signed [15:0] x);
      longint d;
      logic signed [15:0] y;
      d = longint'(hpf_y_prev) + longint'(x) - longint'(hpf_x_prev);
      y = clamp16((eff_alpha() * d) / longint'(ALPHA_ONE));
      hpf_x_prev = x;
      hpf_y_prev = y;
      return y;
   endfunction

   // One-pole lowpass, updates its own memory
   function automatic logic signed [15:0] lp_stage(input logic signed [15:0] x);
      longint a;
      logic signed [15:0] y;
      a = eff_alpha();
      y = clamp16((a * longint'(x) + (longint'(ALPHA_ONE) - a) * longint'(lpf_y_prev))
                  / longint'(ALPHA_ONE));
      lpf_y_prev = y;
      return y;
   endfunction

   // Apply gain and queue one expected result
   function automatic void push_result(input logic signed [15:0] s, input logic fe,
                                       input logic rl);
      longint g;
      chain_result_type r;
      g = (cfg_gain > GAIN_MAX) ? longint'(GAIN_MAX) : longint'(cfg_gain);
      r.sample    = clamp16((longint'(s) * g) / (longint'(1) << GAIN_SHIFT));
      r.frame_end = fe;
      r.run_last  = rl;
      results_due.push_back(r);
   endfunction

   // Filter, 3-tap frame window and gain for one accepted transaction
   function automatic void chain_step(input logic signed [15:0] x, input logic last);
      logic signed [15:0] f;
      longint mag, th;
      int avg;
      case (cfg_mode)
         MODE_LOWPASS:  f = lp_stage(x);
         MODE_HIGHPASS: f = hp_stage(x);
         MODE_BANDPASS: f = lp_stage(hp_stage(x));
         MODE_GATE: begin
            mag = (x < 0) ? -longint'(x) : longint'(x);
            th  = (cfg_thresh > THRESH_MAX) ? longint'(THRESH_MAX) : longint'(cfg_thresh);
            f   = (mag < th) ? 16'sd0 : x;
         end
         default:       f = x;
      endcase
      if (frame_fill == 0) begin
         if (last) begin
            push_result(f, 1'b1, 1'b1);
         end else begin
            tap_new    = f;
            frame_fill = 1;
         end
      end else begin
         // frame start passes unaveraged, interior gets the centered average
         if (frame_fill == 1) begin
            push_result(tap_new, 1'b0, !last);
         end else begin
            avg = (int'(tap_old) + int'(tap_new) + int'(f)) / 3;
            push_result(16'(avg), 1'b0, !last);
         end
         if (last) begin
            push_result(f, 1'b1, 1'b1);
            frame_fill = 0;
         end else begin
            tap_old    = tap_new;
            tap_new    = f;
            frame_fill = 2;
         end
      end
   endfunction

   function automatic logic [15:0] pick_sample(input sample_flavor_type flavor);
      int th;
      int v;
      case (flavor)
         FLAV_FULL:    v = int'($urandom_range(0, 65535)) - 32768;
         FLAV_EXTREME: v = $urandom_range(0, 1) ? 32767 : -32768;
         FLAV_NEAR_GATE: begin
            th = (cfg_thresh > THRESH_MAX) ? int'(THRESH_MAX) : int'(cfg_thresh);
            v  = th + int'($urandom_range(0, 4)) - 2;
            if ($urandom_range(0, 1)) v = -v;
         end
         default:      v = int'($urandom_range(0, 600)) - 300;
      endcase
      return 16'(v);
   endfunction

   task automatic queue_item(input logic [15:0] s, input logic fe);
      sample_item_type it;
      it.sample    = s;
      it.frame_end = fe;
      samples_to_send.push_back(it);
   endtask

   // Register write, mirrored into the predictor (block is idle here)
   task automatic write_reg(input csr_index_type idx, input logic [15:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_MODE: begin
            cfg_mode   = value[2:0];
            hpf_y_prev = '0;
            lpf_y_prev = '0;
         end
         CSR_ALPHA:  cfg_alpha  = value;
         CSR_THRESH: cfg_thresh = value[13:0];
         CSR_GAIN:   cfg_gain   = value;
         default: ;
      endcase
   endtask

   // Wait until every item is sent and every result is in, then settle
   task automatic drain();
      while (samples_to_send.size() != 0 || req_valid || results_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic flag_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
   endtask

   // Driver: offers queued samples, predicts on every accepted transaction
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) chain_step(req_sample_in, req_frame_end_in);
         if (!req_valid || req_ready) begin
            if (samples_to_send.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
               next_item = samples_to_send.pop_front();
               req_valid        <= 1'b1;
               req_sample_in    <= next_item.sample;
               req_frame_end_in <= next_item.frame_end;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off counter
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_arm) begin
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Receiver backpressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // Monitor: compare each result transaction with the oldest expectation
   always @(posedge clock) begin
      chain_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (results_due.size() == 0) begin
            flag_mismatch($sformatf("unexpected result: sample %0d frame_end %b run_last %b",
                                    $signed(rsp_sample_out), rsp_frame_end_out,
                                    rsp_run_last));
         end else begin
            want = results_due.pop_front();
            if (rsp_sample_out !== want.sample || rsp_frame_end_out !== want.frame_end ||
                rsp_run_last !== want.run_last)
               flag_mismatch($sformatf(
                  "mismatch: sample %0d/%0d frame_end %b/%b run_last %b/%b (exp/act)",
                  $signed(want.sample), $signed(rsp_sample_out), want.frame_end,
                  rsp_frame_end_out, want.run_last, rsp_run_last));
         end
      end
   end

   // Stimulus: directed frames, then randomized phases
   initial begin : stimulus
      int                p;
      int                sent;
      int                frame_len;
      sample_flavor_type flavor;
      logic [2:0]        mode_code;
      logic [15:0]       value;
      mode_type          mode_plan [10];

      mode_plan = '{MODE_LOWPASS, MODE_HIGHPASS, MODE_BANDPASS, MODE_GATE, MODE_NONE,
                    MODE_BANDPASS, MODE_LOWPASS, MODE_HIGHPASS, MODE_GATE, MODE_BANDPASS};

      // predictor reset state
      cfg_mode   = MODE_NONE;
      cfg_alpha  = ALPHA_RESET;
      cfg_thresh = THRESH_RESET;
      cfg_gain   = GAIN_RESET;
      hpf_x_prev = '0;
      hpf_y_prev = '0;
      lpf_y_prev = '0;
      tap_old    = '0;
      tap_new    = '0;
      frame_fill = 0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Reset config: one-sample, two-sample, longer frames with extremes
      queue_item(16'h7FFF, 1'b1);
      queue_item(16'h8000, 1'b0);
      queue_item(16'h7FFF, 1'b1);
      queue_item(16'h7FFF, 1'b0);
      queue_item(16'h7FFF, 1'b0);
      queue_item(16'h8000, 1'b0);
      queue_item(16'h8000, 1'b0);
      queue_item(16'hFFFF, 1'b1);
      queue_item(16'h0000, 1'b0);
      queue_item(16'h0001, 1'b0);
      queue_item(16'hFFFF, 1'b1);
      drain();

      // Highpass with oversized alpha and gain: saturation everywhere
      write_reg(CSR_ALPHA, 16'hFFFF);
      write_reg(CSR_GAIN, 16'hFFFF);
      write_reg(CSR_MODE, {13'($urandom()), 3'(MODE_HIGHPASS)});
      queue_item(16'h7FFF, 1'b0);
      queue_item(16'h8000, 1'b0);
      queue_item(16'h7FFF, 1'b0);
      queue_item(16'h8000, 1'b0);
      queue_item(16'h0000, 1'b0);
      queue_item(16'h7FFF, 1'b1);
      drain();

      // Gate with oversized threshold: edges around the clamped limit
      write_reg(CSR_THRESH, 16'hFFFF);
      write_reg(CSR_GAIN, GAIN_RESET);
      write_reg(CSR_MODE, {13'($urandom()), 3'(MODE_GATE)});
      queue_item(16'd9999, 1'b0);
      queue_item(-16'sd10000, 1'b0);
      queue_item(16'd10000, 1'b0);
      queue_item(-16'sd9999, 1'b0);
      queue_item(16'h8000, 1'b1);
      drain();

      // Random phases, each with its own register set and idling pattern
      for (p = 0; p < PHASES; p++) begin
         case (p % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 68; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 68; end
            default: begin gap_pct = 32; stall_pct = 32; end
         endcase

         case (p % 4)
            0: value = 16'(ALPHA_ONE);
            1: value = 16'd0;
            2: value = 16'($urandom_range(32769, 65535));
            default: value = 16'($urandom_range(0, 32768));
         endcase
         write_reg(CSR_ALPHA, value);

         case (p % 3)
            0: value = 16'($urandom_range(0, 10000));
            1: value = (p % 2) ? 16'(THRESH_MAX) : 16'd0;
            default: value = 16'($urandom_range(10001, 65535));
         endcase
         write_reg(CSR_THRESH, value);

         case (p % 5)
            0: value = GAIN_RESET;
            1: value = GAIN_MAX;
            2: value = 16'($urandom_range(40961, 65535));
            3: value = 16'($urandom_range(0, 8192));
            default: value = 16'd0;
         endcase
         write_reg(CSR_GAIN, value);

         // last phases use the unused mode codes
         if (p < 10) mode_code = mode_plan[p];
         else mode_code = 3'(MODE_GATE) + 3'($urandom_range(1, 3));
         write_reg(CSR_MODE, {13'($urandom()), mode_code});

         sent = 0;
         while (sent < PHASE_ITEMS) begin
            if ($urandom_range(0, 9) < 8) begin
               // well-formed frame with random content
               frame_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3)
                                                        : $urandom_range(4, 24);
               flavor = sample_flavor_type'($urandom_range(0, 3));
               for (int i = 0; i < frame_len; i++)
                  queue_item(pick_sample(flavor), i == frame_len - 1);
               sent += frame_len;
            end else begin
               // noise: random end flags
               queue_item(16'($urandom()), 1'($urandom_range(0, 1)));
               sent++;
            end
         end

         // receiver holds off while the sender keeps offering
         if (p == PRESSURE_PHASE) begin
            @(posedge clock);
            hold_arm <= 1'b1;
            @(posedge clock);
            hold_arm <= 1'b0;
         end
         drain();
      end

      if (results_due.size() != 0)
         $display("%0d expected results never arrived", results_due.size());
      if (mismatches == 0 && results_due.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Run limit
   initial begin : watchdog
      #5_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
